### design/c_subset_lexical_scanner_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the lexical scanner core
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef C_SUBSET_LEXICAL_SCANNER_CORE_ASSERT_SVH
`define C_SUBSET_LEXICAL_SCANNER_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define CSLS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// antecedent at one edge implies consequent at the next
`define CSLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/csls_pkg.sv
// ---------------------------------------------------------------------------
// csls_pkg
// Types, constants and character classes for the C subset lexical scanner.
// ---------------------------------------------------------------------------
package csls_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int FIELD_WIDTH = 16;
  localparam int PREFIX_LEN  = 6;
  localparam int KW_COUNT    = 11;
  localparam int FIFO_AW     = 2;
  localparam int FIFO_DEPTH  = 1 << FIFO_AW;

  localparam logic [COORD_WIDTH-1:0] COORD_MAX = {COORD_WIDTH{1'b1}};

  localparam logic [1:0] KIND_KEYWORD = 2'd0;
  localparam logic [1:0] KIND_IDENT   = 2'd1;
  localparam logic [1:0] KIND_NUMBER  = 2'd2;
  localparam logic [1:0] KIND_SYMBOL  = 2'd3;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_EOF  = 1'b1;

  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_UNDER   = 8'h5F;

  // first character in the top byte, zero padded on the right
  localparam logic [8*PREFIX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
    {"int", 24'h0}, {"float", 8'h0}, "double", {"char", 16'h0},
    {"if", 32'h0}, {"else", 16'h0}, {"while", 8'h0}, {"for", 24'h0},
    "return", {"void", 16'h0}, {"main", 16'h0}
  };

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd3, 3'd5, 3'd6, 3'd4, 3'd2, 3'd4, 3'd5, 3'd3, 3'd6, 3'd4, 3'd4
  };

  typedef struct packed {
    logic [1:0]             token_kind;
    logic [3:0]             keyword_index;
    logic [7:0]             symbol_first;
    logic [7:0]             symbol_second;
    logic [FIELD_WIDTH-1:0] line_number;
    logic [FIELD_WIDTH-1:0] start_column;
    logic                   last_of_run;
  } token_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == CH_UNDER;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_single_symbol(input logic [7:0] b);
    return b == CH_PLUS || b == CH_MINUS || b == CH_SEMI || b == CH_COMMA ||
           b == CH_LPAREN || b == CH_RPAREN || b == CH_LBRACE || b == CH_RBRACE;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] sat_inc(input logic [COORD_WIDTH-1:0] v);
    return (v == COORD_MAX) ? v : v + 1'b1;
  endfunction

endpackage

### design/c_subset_lexical_scanner_core.sv
// ---------------------------------------------------------------------------
// c_subset_lexical_scanner_core
// Byte-serial tokenizer for a small C subset with line and column tracking.
//
// Accepts one source byte (or an end-of-input word) per cycle and emits
// tokens with the line and column of their first character. Each byte is
// classified and the scanner state updated in the cycle it is accepted; the
// resulting tokens, at most two per byte, go into a four-entry output queue
// and show on the output from the next cycle on. in_ready stays high while
// at least two queue entries are free. A byte that yields two tokens always
// leaves the scanner idle, so a consumer that takes one token per cycle never
// stalls the input and the block sustains one input word per clock; a slower
// consumer stalls the input whenever three or more tokens wait.
// ---------------------------------------------------------------------------
`include "c_subset_lexical_scanner_core_assert.svh"

module c_subset_lexical_scanner_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_text_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_token_kind,
  output logic [3:0]  out_keyword_index,
  output logic [7:0]  out_symbol_first,
  output logic [7:0]  out_symbol_second,
  output logic [15:0] out_line_number,
  output logic [15:0] out_start_column,
  output logic        out_last_of_run
);

  localparam int CW    = csls_pkg::COORD_WIDTH;
  localparam int FW    = csls_pkg::FIELD_WIDTH;
  localparam int AW    = csls_pkg::FIFO_AW;
  localparam int CNT_W = AW + 1;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NAME,
    MODE_NUM,
    MODE_OP
  } mode_t;

  mode_t               mode_r, mode_nxt;
  logic [7:0]          pend_r, pend_nxt;
  logic [CW-1:0]       line_r, line_nxt;
  logic [CW-1:0]       col_r, col_nxt;
  logic [CW-1:0]       tstart_r, tstart_nxt;
  logic [7:0]          prefix_r [csls_pkg::PREFIX_LEN];
  logic [7:0]          prefix_nxt [csls_pkg::PREFIX_LEN];
  logic [2:0]          len_r, len_nxt;

  csls_pkg::token_t    fifo_r [csls_pkg::FIFO_DEPTH];
  logic [AW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]    count_r;

  logic                accept, pop;
  logic                r0_v, r1_v;
  csls_pkg::token_t    r0, r1, flush_tok, first_tok;
  logic [CW-1:0]       col_inc;
  logic [8*csls_pkg::PREFIX_LEN-1:0] prefix_flat;
  logic                kw_hit;
  logic [3:0]          kw_idx;
  logic [1:0]          push_n;
  logic [7:0]          b;

  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;
  assign in_ready = count_r <= CNT_W'(csls_pkg::FIFO_DEPTH - 2);
  assign b        = in_text_byte;
  assign col_inc  = csls_pkg::sat_inc(col_r);

  always_comb begin
    prefix_flat = '0;
    for (int i = 0; i < csls_pkg::PREFIX_LEN; i++) begin
      prefix_flat[8*(csls_pkg::PREFIX_LEN-1-i) +: 8] = prefix_r[i];
    end
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int k = csls_pkg::KW_COUNT - 1; k >= 0; k--) begin
      if (len_r == csls_pkg::KW_LEN[k] && prefix_flat == csls_pkg::KW_TEXT[k]) begin
        kw_hit = 1'b1;
        kw_idx = 4'(k);
      end
    end
  end

  always_comb begin
    flush_tok               = '0;
    flush_tok.line_number   = FW'(line_r);
    flush_tok.start_column  = FW'(tstart_r);
    unique case (mode_r)
      MODE_NAME: begin
        flush_tok.token_kind    = kw_hit ? csls_pkg::KIND_KEYWORD : csls_pkg::KIND_IDENT;
        flush_tok.keyword_index = kw_hit ? kw_idx : 4'd0;
      end
      MODE_NUM: flush_tok.token_kind = csls_pkg::KIND_NUMBER;
      MODE_OP: begin
        flush_tok.token_kind   = csls_pkg::KIND_SYMBOL;
        flush_tok.symbol_first = pend_r;
      end
      default: flush_tok.token_kind = csls_pkg::KIND_IDENT;
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    pend_nxt   = pend_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    tstart_nxt = tstart_r;
    prefix_nxt = prefix_r;
    len_nxt    = len_r;
    r0_v       = 1'b0;
    r1_v       = 1'b0;
    r0         = flush_tok;
    r1         = '0;
    r1.token_kind   = csls_pkg::KIND_SYMBOL;
    r1.symbol_first = b;
    r1.line_number  = FW'(line_r);
    r1.start_column = FW'(col_inc);
    r1.last_of_run  = 1'b1;

    if (in_action == csls_pkg::ACT_EOF) begin
      r0_v     = (mode_r != MODE_IDLE);
      mode_nxt = MODE_IDLE;
      pend_nxt = '0;
    end else begin
      col_nxt = col_inc;
      if (mode_r == MODE_NAME && (csls_pkg::is_letter(b) || csls_pkg::is_digit(b))) begin
        if (len_r < 3'(csls_pkg::PREFIX_LEN)) begin
          prefix_nxt[len_r] = b;
        end
        if (len_r != 3'd7) begin
          len_nxt = len_r + 3'd1;
        end
      end else if (mode_r == MODE_NUM && csls_pkg::is_digit(b)) begin
        mode_nxt = MODE_NUM;
      end else if (mode_r == MODE_OP && b == csls_pkg::CH_EQ) begin
        r0_v             = 1'b1;
        r0.symbol_second = csls_pkg::CH_EQ;
        mode_nxt         = MODE_IDLE;
        pend_nxt         = '0;
      end else begin
        r0_v     = (mode_r != MODE_IDLE);
        mode_nxt = MODE_IDLE;
        pend_nxt = '0;
        if (b == csls_pkg::CH_NEWLINE) begin
          line_nxt = csls_pkg::sat_inc(line_r);
          col_nxt  = '0;
        end else if (csls_pkg::is_letter(b)) begin
          mode_nxt   = MODE_NAME;
          tstart_nxt = col_inc;
          for (int i = 0; i < csls_pkg::PREFIX_LEN; i++) begin
            prefix_nxt[i] = '0;
          end
          prefix_nxt[0] = b;
          len_nxt       = 3'd1;
        end else if (csls_pkg::is_digit(b)) begin
          mode_nxt   = MODE_NUM;
          tstart_nxt = col_inc;
        end else if (b == csls_pkg::CH_EQ || b == csls_pkg::CH_LT || b == csls_pkg::CH_GT) begin
          mode_nxt   = MODE_OP;
          pend_nxt   = b;
          tstart_nxt = col_inc;
        end else if (csls_pkg::is_single_symbol(b)) begin
          r1_v = 1'b1;
        end
      end
    end
    r0.last_of_run = !r1_v;
    first_tok      = r0_v ? r0 : r1;
    push_n         = {1'b0, r0_v} + {1'b0, r1_v};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pend_r   <= '0;
      line_r   <= CW'(1);
      col_r    <= '0;
      tstart_r <= '0;
      len_r    <= '0;
      for (int i = 0; i < csls_pkg::PREFIX_LEN; i++) begin
        prefix_r[i] <= '0;
      end
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (accept) begin
        mode_r   <= mode_nxt;
        pend_r   <= pend_nxt;
        line_r   <= line_nxt;
        col_r    <= col_nxt;
        tstart_r <= tstart_nxt;
        prefix_r <= prefix_nxt;
        len_r    <= len_nxt;
        if (push_n != 2'd0) begin
          fifo_r[wr_ptr_r] <= first_tok;
        end
        if (push_n == 2'd2) begin
          fifo_r[wr_ptr_r + 1'b1] <= r1;
        end
        wr_ptr_r <= wr_ptr_r + AW'(push_n);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (accept ? CNT_W'(push_n) : CNT_W'(0)) - CNT_W'(pop);
    end
  end

  assign out_valid         = count_r != '0;
  assign out_token_kind    = fifo_r[rd_ptr_r].token_kind;
  assign out_keyword_index = fifo_r[rd_ptr_r].keyword_index;
  assign out_symbol_first  = fifo_r[rd_ptr_r].symbol_first;
  assign out_symbol_second = fifo_r[rd_ptr_r].symbol_second;
  assign out_line_number   = fifo_r[rd_ptr_r].line_number;
  assign out_start_column  = fifo_r[rd_ptr_r].start_column;
  assign out_last_of_run   = fifo_r[rd_ptr_r].last_of_run;

  `CSLS_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(csls_pkg::FIFO_DEPTH), "queue overfilled")
  `CSLS_ASSERT_NEXT(a_double_push, accept && r0_v && r1_v && !pop, count_r == $past(count_r) + 2, "two-token push lost an entry")
  `CSLS_ASSERT_ALWAYS(a_line_nonzero, line_r != '0, "line counter reached zero")
  `CSLS_ASSERT_ALWAYS(a_op_pending, mode_r != MODE_OP || pend_r == csls_pkg::CH_EQ || pend_r == csls_pkg::CH_LT || pend_r == csls_pkg::CH_GT, "bad pending operator")
  `CSLS_ASSERT_ALWAYS(a_idle_clear, mode_r != MODE_IDLE || pend_r == '0, "pending operator left while idle")

endmodule
